>>> design/iaol_pkg.sv
package iaol_pkg;

    localparam int TW = 31;
    localparam int DW = 8;

    typedef struct packed {
        logic [TW-1:0] interval_start;
        logic [TW-1:0] interval_end;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } t_out;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [7:0] LIMIT_RESET = 8'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic          done;
        logic          adv;
        logic          clr_s;
        logic          clr_e;
        logic          emit;
        logic          ovf;
        logic          ovl;
        logic [TW-1:0] time_v;
        logic [DW-1:0] delta;
    } t_step;

endpackage

>>> design/iaol_ram.sv
module iaol_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/iaol_step.sv
module iaol_step
    import iaol_pkg::*;
#(
    parameter int SW = 16
) (
    input  logic                 i_has_ent,
    input  logic [TW-1:0]        i_ent_t,
    input  logic signed [DW-1:0] i_ent_d,
    input  logic [TW-1:0]        i_s,
    input  logic [TW-1:0]        i_e,
    input  logic                 i_ps,
    input  logic                 i_pe,
    input  logic signed [SW-1:0] i_sum,
    input  logic [7:0]           i_limit,
    output t_step                o_step,
    output logic signed [SW-1:0] o_sum
);

    logic signed [DW:0] d9;
    logic               eq_s;
    logic               eq_e;

    assign eq_s = (i_ent_t == i_s);
    assign eq_e = (i_ent_t == i_e);

    always_comb begin
        o_step = '0;
        d9     = '0;
        if (i_ps && (!i_has_ent || i_s < i_ent_t)) begin
            o_step.time_v = i_s;
            o_step.clr_s  = 1'b1;
            d9            = 9'sd1;
        end else if (i_pe && (!i_has_ent || i_e < i_ent_t)) begin
            o_step.time_v = i_e;
            o_step.clr_e  = 1'b1;
            d9            = -9'sd1;
        end else if (i_has_ent) begin
            o_step.time_v = i_ent_t;
            o_step.adv    = 1'b1;
            o_step.clr_s  = eq_s;
            o_step.clr_e  = eq_e;
            d9 = {i_ent_d[DW-1], i_ent_d} + (eq_s ? 9'sd1 : 9'sd0) - (eq_e ? 9'sd1 : 9'sd0);
        end else begin
            o_step.done = 1'b1;
        end
        o_sum        = i_sum + SW'(d9);
        o_step.delta = d9[DW-1:0];
        o_step.emit  = (d9 != 9'sd0);
        o_step.ovf   = (d9 > 9'sd127) || (d9 < -9'sd128);
        o_step.ovl   = !o_step.done && (o_sum >= $signed({{(SW-8){1'b0}}, i_limit}));
    end

endmodule

>>> design/interval_admission_overlap_limit_top.sv
// An invalid interval answers in the cycle after acceptance.
// An accepted request runs a check walk over the N stored breakpoints, then a rebuild walk;
// a refused one ends after the check walk. Each entry is read on the RAM read port in S_RD.
// Throughput: one request at a time; input stalls until the result beat leaves.
// Reset (synchronous, active low) empties the table and sets the limit to 3.
module interval_admission_overlap_limit_top
    import iaol_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out       o_out,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = AW + 10;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_k, n_k;
    logic                 r_bank, n_bank;
    logic [7:0]           r_limit;
    logic [TW-1:0]        r_s, n_s;
    logic [TW-1:0]        r_e, n_e;
    logic                 r_ps, n_ps;
    logic                 r_pe, n_pe;
    logic                 r_hs, n_hs;
    logic                 r_he, n_he;
    logic                 r_ovf, n_ovf;
    logic                 r_ovl, n_ovl;
    logic                 r_commit, n_commit;
    logic signed [SW-1:0] r_sum, n_sum;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic [TW+DW-1:0] rd0, rd1, rd;
    logic             we;
    logic [1:0]       needed;
    t_step            st;
    logic signed [SW-1:0] st_sum;

    iaol_ram #(.WIDTH(TW + DW), .DEPTH(TABLE_DEPTH)) u_ram0 (
        .i_clk  (i_clk),
        .i_we   (we && r_bank),
        .i_waddr(r_k[AW-1:0]),
        .i_wdata({st.time_v, st.delta}),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rd0)
    );

    iaol_ram #(.WIDTH(TW + DW), .DEPTH(TABLE_DEPTH)) u_ram1 (
        .i_clk  (i_clk),
        .i_we   (we && !r_bank),
        .i_waddr(r_k[AW-1:0]),
        .i_wdata({st.time_v, st.delta}),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rd1)
    );

    assign rd = r_bank ? rd1 : rd0;

    iaol_step #(.SW(SW)) u_step (
        .i_has_ent(r_idx < r_count),
        .i_ent_t  (rd[TW+DW-1:DW]),
        .i_ent_d  (rd[DW-1:0]),
        .i_s      (r_s),
        .i_e      (r_e),
        .i_ps     (r_ps),
        .i_pe     (r_pe),
        .i_sum    (r_sum),
        .i_limit  (r_limit),
        .o_step   (st),
        .o_sum    (st_sum)
    );

    assign needed = {1'b0, !r_hs} + {1'b0, !r_he};
    assign we     = (r_state == S_EV) && r_commit && !st.done && st.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bank      <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_s      <= n_s;
        r_e      <= n_e;
        r_ps     <= n_ps;
        r_pe     <= n_pe;
        r_hs     <= n_hs;
        r_he     <= n_he;
        r_ovf    <= n_ovf;
        r_ovl    <= n_ovl;
        r_commit <= n_commit;
        r_sum    <= n_sum;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_k         = r_k;
        n_bank      = r_bank;
        n_s         = r_s;
        n_e         = r_e;
        n_ps        = r_ps;
        n_pe        = r_pe;
        n_hs        = r_hs;
        n_he        = r_he;
        n_ovf       = r_ovf;
        n_ovl       = r_ovl;
        n_commit    = r_commit;
        n_sum       = r_sum;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_s = i_in.interval_start;
                    n_e = i_in.interval_end;
                    if (i_in.interval_start >= i_in.interval_end) begin
                        n_out       = '{accepted: 1'b0, status: ST_INVALID};
                        n_out_valid = 1'b1;
                    end else begin
                        n_idx    = '0;
                        n_k      = '0;
                        n_sum    = '0;
                        n_ps     = 1'b1;
                        n_pe     = 1'b1;
                        n_hs     = 1'b0;
                        n_he     = 1'b0;
                        n_ovf    = 1'b0;
                        n_ovl    = 1'b0;
                        n_commit = 1'b0;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (st.done) begin
                    if (r_commit) begin
                        n_count     = r_k;
                        n_bank      = !r_bank;
                        n_out       = '{accepted: 1'b1, status: ST_OK};
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_sum = st_sum;
                    n_ovf = r_ovf || st.ovf;
                    n_ovl = r_ovl || st.ovl;
                    if (st.clr_s) n_ps = 1'b0;
                    if (st.clr_e) n_pe = 1'b0;
                    if (st.adv && st.clr_s) n_hs = 1'b1;
                    if (st.adv && st.clr_e) n_he = 1'b1;
                    if (we) n_k = r_k + 1'b1;
                    if (st.adv) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if ((CW+1)'(r_count) + (CW+1)'(needed) > (CW+1)'(TABLE_DEPTH) || r_ovf) begin
                    n_out       = '{accepted: 1'b0, status: ST_FULL};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_ovl) begin
                    n_out       = '{accepted: 1'b0, status: ST_OVERLAP};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx    = '0;
                    n_k      = '0;
                    n_ps     = 1'b1;
                    n_pe     = 1'b1;
                    n_commit = 1'b1;
                    n_state  = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.accepted |-> o_out.status == ST_OK)
        else $error("accepted beat with non-ok status");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("input open while busy");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_k < CW'(TABLE_DEPTH))
        else $error("write past table end");

endmodule

>>> dv/interval_admission_overlap_limit_top_tb.sv
module interval_admission_overlap_limit_top_tb;
    import iaol_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef struct {
        logic [TW-1:0] s;
        logic [TW-1:0] e;
        bit            typed;
        t_out          res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in        i_in;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out       o_out;
    logic       i_out_stall;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    logic [TW-1:0] bkpt_time[$];
    int            bkpt_delta[$];
    logic [7:0]    limit_q;
    t_out          pending_q[$];

    int  snd_idle;
    int  rcv_idle;
    int  hold_cycles;
    bit  hold_req;
    bit  failed;

    interval_admission_overlap_limit_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_out book_interval(logic [TW-1:0] s, logic [TW-1:0] e);
        t_out          r;
        logic [TW-1:0] wt[$];
        int            wd[$];
        logic [TW-1:0] t;
        int            d;
        int            needed;
        int            i;
        int            sum;
        bit            hs;
        bit            he;
        r.accepted = 1'b0;
        r.status = ST_INVALID;
        if (s >= e) return r;
        hs = 0;
        he = 0;
        foreach (bkpt_time[k]) begin
            if (bkpt_time[k] == s) hs = 1;
            if (bkpt_time[k] == e) he = 1;
        end
        needed = (hs ? 0 : 1) + (he ? 0 : 1);
        r.status = ST_FULL;
        if (bkpt_time.size() + needed > DEPTH) return r;
        wt = bkpt_time;
        wd = bkpt_delta;
        for (int j = 0; j < 2; j++) begin
            t = (j == 0) ? s : e;
            d = (j == 0) ? 1 : -1;
            i = 0;
            while (i < wt.size() && wt[i] < t) i++;
            if (i < wt.size() && wt[i] == t) begin
                wd[i] += d;
            end else begin
                wt.insert(i, t);
                wd.insert(i, d);
            end
        end
        foreach (wd[k]) if (wd[k] > 127 || wd[k] < -128) return r;
        sum = 0;
        r.status = ST_OVERLAP;
        foreach (wd[k]) begin
            sum += wd[k];
            if (sum >= int'(limit_q)) return r;
        end
        bkpt_time = {};
        bkpt_delta = {};
        foreach (wd[k]) begin
            if (wd[k] != 0) begin
                bkpt_time.push_back(wt[k]);
                bkpt_delta.push_back(wd[k]);
            end
        end
        r.accepted = 1'b1;
        r.status = ST_OK;
        return r;
    endfunction

    task automatic send_request(logic [TW-1:0] s, logic [TW-1:0] e, bit typed, t_out res);
        t_out p;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in.interval_start <= s;
        i_in.interval_end <= e;
        do @(posedge i_clk); while (o_in_stall);
        p = book_interval(s, e);
        pending_q.push_back(typed ? res : p);
    endtask

    task automatic write_limit(logic [7:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_q = v;
    endtask

    task automatic random_requests(int count);
        logic [TW-1:0] s;
        logic [TW-1:0] e;
        int            pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                s = TW'($urandom);
                e = TW'($urandom);
            end else if (pick < 12) begin
                s = TW'($urandom_range(40));
                e = TW'($urandom_range(32'(s)));
            end else begin
                s = TW'($urandom_range(39));
                e = s + TW'($urandom_range(40 - 32'(s), 1));
            end
            send_request(s, e, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result beat with no request outstanding");
                failed = 1;
            end else begin
                if (o_out.accepted !== pending_q[0].accepted) begin
                    $error("accepted: expected %0d, got %0d",
                           pending_q[0].accepted, o_out.accepted);
                    failed = 1;
                end
                if (o_out.status !== pending_q[0].status) begin
                    $error("status: expected %0d, got %0d",
                           pending_q[0].status, o_out.status);
                    failed = 1;
                end
                void'(pending_q.pop_front());
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cycles <= 600;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    t_row rows[$];

    initial begin
        failed = 0;
        hold_req = 0;
        hold_cycles = 0;
        snd_idle = 24;
        rcv_idle = 63;
        limit_q = LIMIT_RESET;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{31'd5, 31'd5, 1'b1, '{1'b0, ST_INVALID}},
            '{31'd9, 31'd3, 1'b1, '{1'b0, ST_INVALID}},
            '{TMAX, 31'd0, 1'b1, '{1'b0, ST_INVALID}},
            '{31'd0, 31'd10, 1'b1, '{1'b1, ST_OK}},
            '{31'd0, 31'd10, 1'b1, '{1'b1, ST_OK}},
            '{31'd0, 31'd10, 1'b1, '{1'b0, ST_OVERLAP}},
            '{31'd10, 31'd20, 1'b1, '{1'b1, ST_OK}},
            '{TMAX - 1, TMAX, 1'b1, '{1'b1, ST_OK}},
            '{31'd0, TMAX, 1'b1, '{1'b0, ST_OVERLAP}},
            '{31'd5, 31'd15, 1'b0, '0},
            '{31'h2AAAAAAA, 31'h55555555, 1'b0, '0},
            '{31'd19, 31'd21, 1'b0, '0},
            '{31'd3, 31'd4, 1'b0, '0}
        };
        foreach (rows[k]) send_request(rows[k].s, rows[k].e, rows[k].typed, rows[k].res);

        // drive one breakpoint's delta past the signed 8-bit range
        write_limit(8'd255);
        for (int n = 0; n < 130; n++) send_request(31'd50, 31'd51, 1'b0, '0);

        write_limit(8'd2);
        random_requests(80);

        write_limit(8'd1);
        random_requests(8);

        write_limit(8'd3);
        snd_idle = 63;
        rcv_idle = 24;
        hold_req = 1;
        random_requests(80);

        write_limit(8'($urandom_range(254, 2)));
        snd_idle = 0;
        rcv_idle = 0;
        random_requests(80);
        for (int n = 0; n < 40; n++) begin
            send_request(31'(2000 + 2 * n), 31'(2001 + 2 * n), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
design/iaol_pkg.sv
design/iaol_ram.sv
design/iaol_step.sv
design/interval_admission_overlap_limit_top.sv
dv/interval_admission_overlap_limit_top_tb.sv
